// ----- rtl/core/imhdk_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imhdk_pkg: shared definitions of the indexed min-heap
// Widths of the fixed fields, default parameter values, command and status
// codes.
// ----------------------------------------------------------------------------
package imhdk_pkg;

  // Fixed field widths.
  localparam int VERTEX_BITS   = 10;
  localparam int KEY_PORT_BITS = 31;
  localparam int NUM_VERTICES  = 1024;

  // Defaults for the top level parameters.
  localparam int DEF_CAPACITY = 1024;
  localparam int DEF_KEY_BITS = 31;

  // Command codes.
  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_EXTRACT  = 2'd1;
  localparam logic [1:0] CMD_DECREASE = 2'd2;
  localparam logic [1:0] CMD_QUERY    = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

endpackage
`default_nettype wire

// ----- rtl/core/indexed_min_heap_decrease_key.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key: indexed binary min-heap with decrease-key
// Heap entries and the vertex-to-position table live in two synchronous
// memories; a sequencer walks the heap one level at a time.
// ----------------------------------------------------------------------------
// Each command transaction produces exactly one result transaction. After
// reset the position table is swept to "absent", one entry per cycle, with
// in_stall held high until every entry is cleared. Each level of a sift is
// split into steps, since the heap memory has a single registered read port:
// sift-up reads the parent, then compares and writes back; sift-down reads
// the left child, then the right child, then compares and writes back.
// A finished result sits in an output register, so the next command is
// taken while it waits unless a second result would have to overwrite it.
module indexed_min_heap_decrease_key #(
  parameter int CAPACITY = imhdk_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = imhdk_pkg::DEF_KEY_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_command,
  input  wire logic [imhdk_pkg::VERTEX_BITS-1:0]  in_vertex,
  input  wire logic [imhdk_pkg::KEY_PORT_BITS-1:0] in_key_in,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [imhdk_pkg::VERTEX_BITS-1:0]       out_vertex,
  output logic [imhdk_pkg::KEY_PORT_BITS-1:0]     out_key,
  output logic                                    out_is_member,
  output logic [1:0]                              out_status
);

  localparam int VB = imhdk_pkg::VERTEX_BITS;
  localparam int HW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = VB + KEY_BITS;
  localparam int PA = $clog2(imhdk_pkg::NUM_VERTICES);
  localparam logic [CW-1:0] ABSENT = CW'(CAPACITY);
  localparam logic [PA:0]   CLR_LAST = (PA+1)'(imhdk_pkg::NUM_VERTICES - 1);

  // Sequencer states.
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_POSW = 4'd2;
  localparam logic [3:0] S_DKW  = 4'd3;
  localparam logic [3:0] S_UP   = 4'd4;
  localparam logic [3:0] S_UPW  = 4'd5;
  localparam logic [3:0] S_EXW  = 4'd6;
  localparam logic [3:0] S_EXL  = 4'd7;
  localparam logic [3:0] S_DN   = 4'd8;
  localparam logic [3:0] S_DNL  = 4'd9;
  localparam logic [3:0] S_DNR  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  // Memories.
  logic [EW-1:0] heap_mem [CAPACITY];
  logic [CW-1:0] pos_mem  [imhdk_pkg::NUM_VERTICES];

  logic [EW-1:0] heap_q_r;
  logic [CW-1:0] pos_q_r;

  logic          hw_en;
  logic [HW-1:0] hw_addr;
  logic [EW-1:0] hw_data;
  logic [HW-1:0] hr_addr;
  logic          pw_en;
  logic [PA-1:0] pw_addr;
  logic [CW-1:0] pw_data;

  // Control and working registers.
  logic [3:0]          state_r, state_nxt;
  logic [PA:0]         clr_r, clr_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [VB-1:0]       vtx_r, vtx_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [HW-1:0]       h_r, h_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [KEY_BITS-1:0] lkey_r, lkey_nxt;
  logic [VB-1:0]       lvtx_r, lvtx_nxt;

  logic [VB-1:0]       res_v_r, res_v_nxt;
  logic [KEY_BITS-1:0] res_k_r, res_k_nxt;
  logic                res_m_r, res_m_nxt;
  logic [1:0]          res_s_r, res_s_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VB-1:0]       out_v_r, out_v_nxt;
  logic [KEY_BITS-1:0] out_k_r, out_k_nxt;
  logic                out_m_r, out_m_nxt;
  logic [1:0]          out_s_r, out_s_nxt;

  // Derived values.
  logic [63:0]         key_wide;
  logic [KEY_BITS-1:0] key_ext;
  logic [63:0]         okey_wide;
  logic [VB-1:0]       d_v;
  logic [KEY_BITS-1:0] d_k;
  logic [HW-1:0]       parent;
  logic [CW:0]         left_idx;
  logic [CW:0]         right_idx;
  logic                present;
  logic                out_free;

  assign key_wide  = {33'd0, in_key_in};
  assign key_ext   = key_wide[KEY_BITS-1:0];
  assign okey_wide = {{(64-KEY_BITS){1'b0}}, out_k_r};
  assign d_v       = heap_q_r[EW-1:KEY_BITS];
  assign d_k       = heap_q_r[KEY_BITS-1:0];
  assign parent    = (h_r - HW'(1)) >> 1;
  assign left_idx  = (CW+1)'({h_r, 1'b1});
  assign right_idx = left_idx + (CW+1)'(1);
  assign present   = pos_q_r < count_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_vertex    = out_v_r;
  assign out_key       = okey_wide[imhdk_pkg::KEY_PORT_BITS-1:0];
  assign out_is_member = out_m_r;
  assign out_status    = out_s_r;

  // Heap memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (hw_en) begin
      heap_mem[hw_addr] <= hw_data;
    end
    heap_q_r <= heap_mem[hr_addr];
  end

  // Position memory: read at the incoming vertex, written by the sequencer.
  always_ff @(posedge clk) begin
    if (pw_en) begin
      pos_mem[pw_addr] <= pw_data;
    end
    pos_q_r <= pos_mem[in_vertex];
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    vtx_nxt       = vtx_r;
    key_nxt       = key_r;
    h_nxt         = h_r;
    count_nxt     = count_r;
    lkey_nxt      = lkey_r;
    lvtx_nxt      = lvtx_r;
    res_v_nxt     = res_v_r;
    res_k_nxt     = res_k_r;
    res_m_nxt     = res_m_r;
    res_s_nxt     = res_s_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_v_nxt     = out_v_r;
    out_k_nxt     = out_k_r;
    out_m_nxt     = out_m_r;
    out_s_nxt     = out_s_r;
    hw_en         = 1'b0;
    hw_addr       = h_r;
    hw_data       = heap_q_r;
    hr_addr       = '0;
    pw_en         = 1'b0;
    pw_addr       = d_v;
    pw_data       = CW'(h_r);

    unique case (state_r)
      S_CLR: begin
        pw_en   = 1'b1;
        pw_addr = clr_r[PA-1:0];
        pw_data = ABSENT;
        clr_nxt = clr_r + (PA+1)'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          vtx_nxt   = in_vertex;
          key_nxt   = key_ext;
          res_v_nxt = '0;
          res_k_nxt = '0;
          res_m_nxt = 1'b0;
          res_s_nxt = imhdk_pkg::ST_OK;
          if (in_command == imhdk_pkg::CMD_EXTRACT) begin
            if (count_r == '0) begin
              res_s_nxt = imhdk_pkg::ST_EMPTY;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_EXW;
            end
          end else begin
            state_nxt = S_POSW;
          end
        end
      end
      S_POSW: begin
        // Position of the command's vertex has arrived.
        unique case (cmd_r)
          imhdk_pkg::CMD_INSERT: begin
            if (present) begin
              state_nxt = S_DONE;
            end else if (count_r == CW'(CAPACITY)) begin
              res_s_nxt = imhdk_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else begin
              h_nxt     = count_r[HW-1:0];
              count_nxt = count_r + CW'(1);
              state_nxt = S_UP;
            end
          end
          imhdk_pkg::CMD_DECREASE: begin
            if (!present) begin
              res_s_nxt = imhdk_pkg::ST_ABSENT;
              state_nxt = S_DONE;
            end else begin
              h_nxt     = pos_q_r[HW-1:0];
              hr_addr   = pos_q_r[HW-1:0];
              state_nxt = S_DKW;
            end
          end
          default: begin
            res_m_nxt = present;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DKW: begin
        // Only a strictly smaller key changes anything.
        if (key_r < d_k) begin
          state_nxt = S_UP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_UP: begin
        if (h_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          hr_addr   = parent;
          state_nxt = S_UPW;
        end
      end
      S_UPW: begin
        // Parent moves down into the hole when the moving key is smaller.
        if (key_r < d_k) begin
          hw_en     = 1'b1;
          pw_en     = 1'b1;
          h_nxt     = parent;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EXW: begin
        // Root has arrived: report it, mark it absent, fetch the last entry unless the heap becomes empty.
        res_v_nxt = d_v;
        res_k_nxt = d_k;
        count_nxt = count_r - CW'(1);
        pw_en     = 1'b1;
        pw_data   = ABSENT;
        if (count_r == CW'(1)) begin
          state_nxt = S_DONE;
        end else begin
          hr_addr   = count_nxt[HW-1:0];
          state_nxt = S_EXL;
        end
      end
      S_EXL: begin
        vtx_nxt   = d_v;
        key_nxt   = d_k;
        h_nxt     = '0;
        state_nxt = S_DN;
      end
      S_DN: begin
        if (left_idx < (CW+1)'(count_r)) begin
          hr_addr   = left_idx[HW-1:0];
          state_nxt = S_DNL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DNL: begin
        lkey_nxt = d_k;
        lvtx_nxt = d_v;
        if (right_idx < (CW+1)'(count_r)) begin
          hr_addr   = right_idx[HW-1:0];
          state_nxt = S_DNR;
        end else if (d_k < key_r) begin
          hw_en     = 1'b1;
          pw_en     = 1'b1;
          h_nxt     = left_idx[HW-1:0];
          state_nxt = S_DN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DNR: begin
        // Right child wins only if strictly below the better of the others.
        if (lkey_r < key_r) begin
          hw_en = 1'b1;
          pw_en = 1'b1;
          if (d_k < lkey_r) begin
            h_nxt   = right_idx[HW-1:0];
          end else begin
            // The left child was kept from the previous read.
            hw_data = {lvtx_r, lkey_r};
            pw_addr = lvtx_r;
            h_nxt   = left_idx[HW-1:0];
          end
          state_nxt = S_DN;
        end else if (d_k < key_r) begin
          hw_en     = 1'b1;
          pw_en     = 1'b1;
          h_nxt     = right_idx[HW-1:0];
          state_nxt = S_DN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Moving entry settles into the hole.
        hw_en     = 1'b1;
        hw_data   = {vtx_r, key_r};
        pw_en     = 1'b1;
        pw_addr   = vtx_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_v_nxt     = res_v_r;
          out_k_nxt     = res_k_r;
          out_m_nxt     = res_m_r;
          out_s_nxt     = res_s_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    vtx_r   <= vtx_nxt;
    key_r   <= key_nxt;
    h_r     <= h_nxt;
    lkey_r  <= lkey_nxt;
    lvtx_r  <= lvtx_nxt;
    res_v_r <= res_v_nxt;
    res_k_r <= res_k_nxt;
    res_m_r <= res_m_nxt;
    res_s_r <= res_s_nxt;
    out_v_r <= out_v_nxt;
    out_k_r <= out_k_nxt;
    out_m_r <= out_m_nxt;
    out_s_r <= out_s_nxt;
  end

endmodule
`default_nettype wire
